// File: rtl/dpe_pkg.sv
package dpe_pkg;

    localparam int EXP_TABLE_DEPTH = 256;
    localparam int FRAC_BITS = 16;
    localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_ADDR_W = $clog2(EXP_TABLE_DEPTH + 1);

    localparam int POS_W = 32;
    localparam int WORD_W = 32;
    localparam int REG_W = 2 * WORD_W;
    localparam int LT_W = REG_W - FRAC_BITS;
    localparam int BW = LT_W + 4;
    localparam int DEN_W = 36;
    localparam int REM_W = DEN_W + 3;
    localparam int Q_W = 19;
    localparam int U_W = 2 * Q_W - 1;
    localparam int F_W = 17;
    localparam int TAB_W = 31;

    localparam logic [F_W-1:0] UNIT = 17'h10000;
    localparam logic [F_W-1:0] LEVEL_LOW = 17'd13107;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VACUUM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLASMA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU = 3'd6;

    typedef enum logic [1:0] {
        MODE_BOX   = 2'd0,
        MODE_TRAP  = 2'd1,
        MODE_GAUSS = 2'd2,
        MODE_FIXED = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ZERO      = 3'd0,
        KIND_UNIT      = 3'd1,
        KIND_LEVEL     = 3'd2,
        KIND_RAMP_UP   = 3'd3,
        KIND_RAMP_DOWN = 3'd4,
        KIND_GAUSS     = 3'd5
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } tag_t;

    typedef struct packed {
        logic [WORD_W-1:0] vac;
        logic [WORD_W-1:0] plasma;
        logic [WORD_W-1:0] slope;
        logic [WORD_W-1:0] sigma;
        logic [WORD_W-1:0] cut;
        logic [WORD_W-1:0] plateau;
    } axis_cfg_t;

    function automatic logic signed [BW-1:0] uext(input logic [LT_W-1:0] x);
        return signed'({{(BW - LT_W){1'b0}}, x});
    endfunction

    function automatic logic signed [BW-1:0] thresh(input logic [63:0] k);
        logic [63:0] prod;
        prod = k * 64'd26986075409;
        return BW'(signed'(prod >> (32 - FRAC_BITS)));
    endfunction

    localparam logic signed [BW-1:0] T2 = thresh(64'd2);
    localparam logic signed [BW-1:0] T13 = thresh(64'd13);
    localparam logic signed [BW-1:0] T20 = thresh(64'd20);
    localparam logic signed [BW-1:0] T65 = thresh(64'd65);
    localparam logic signed [BW-1:0] T82 = thresh(64'd82);
    localparam logic signed [BW-1:0] T112 = thresh(64'd112);
    localparam logic signed [BW-1:0] W_UP = T20 - T13;
    localparam logic signed [BW-1:0] W_DN = T82 - T65;
    localparam logic signed [BW-1:0] DEN_UP = 5 * W_UP;
    localparam logic signed [BW-1:0] DEN_DN = 5 * W_DN;
    localparam logic signed [BW-1:0] OFF_UP = 4 * T13 - W_UP;
    localparam logic signed [BW-1:0] OFF_DN = DEN_DN + 4 * T65;

    typedef logic [TAB_W-1:0] exp_tab_t [0:EXP_TABLE_DEPTH];

    // Restoring division by shift and subtract, used only while the table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry i holds exp(-16 i / depth) in Q1.30, built by repeated multiplication.
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t tab;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        logic [63:0] prod;
        term = 64'd1 << 48;
        sum = term;
        for (int k = 1; k <= 20; k++) begin
            term = udiv64(term * 64'd16, 64'(EXP_TABLE_DEPTH) * 64'(k));
            if ((k & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        e = (sum + 64'd32768) >> 16;
        tab[0] = TAB_W'(32'h4000_0000);
        for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
            prod = 64'(tab[i-1]) * e;
            tab[i] = TAB_W'((prod + 64'h8000_0000) >> 32);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// File: rtl/dpe_front.sv
module dpe_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             adv,
    input  logic                             x_axis,
    input  logic                             in_valid,
    input  logic signed [dpe_pkg::POS_W-1:0] pos,
    input  dpe_pkg::mode_t                   mode,
    input  dpe_pkg::axis_cfg_t               cfg,
    output dpe_pkg::tag_t                    tag,
    output logic [dpe_pkg::REM_W-1:0]        num,
    output logic [dpe_pkg::DEN_W-1:0]        den
);
    import dpe_pkg::*;

    logic                    valid_b_reg, valid_c_reg;
    logic signed [POS_W-1:0] pos_b_reg, pos_c_reg;
    logic [LT_W-1:0]         lt_reg, lt_next;
    logic [REG_W-1:0]        lt_prod;

    logic signed [BW-1:0] v, l, s, sg, lt, pl, six;
    logic signed [BW-1:0] e0_next, e1_next, e2_next, e3_next, g1_next, g2_next;
    logic signed [BW-1:0] e0_reg, e1_reg, e2_reg, e3_reg, g1_reg, g2_reg;

    logic signed [BW-1:0] p, p4, num_w;
    kind_t                kind_next;
    logic [DEN_W-1:0]     den_next;
    tag_t                 tag_reg;
    logic [REM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     den_reg;

    always_comb begin
        lt_prod = REG_W'(cfg.cut) * REG_W'(cfg.sigma);
        lt_next = lt_prod[REG_W-1:FRAC_BITS];
    end

    always_comb begin
        v = uext(LT_W'(cfg.vac));
        l = uext(LT_W'(cfg.plasma));
        s = uext(LT_W'(cfg.slope));
        sg = uext(LT_W'(cfg.sigma));
        pl = uext(LT_W'(cfg.plateau));
        lt = uext(lt_reg);
        six = (sg <<< 2) + (sg <<< 1);
        e0_next = v;
        e1_next = v;
        e2_next = v;
        e3_next = v;
        g1_next = v;
        g2_next = v;
        unique case (mode)
            MODE_BOX: begin
                e3_next = v + l;
            end
            MODE_TRAP: begin
                e1_next = v + s;
                e2_next = v + l - s;
                e3_next = v + l;
            end
            MODE_GAUSS: begin
                e1_next = v + lt;
                e2_next = v + lt + pl;
                e3_next = v + (lt <<< 1) + pl;
                g1_next = v + lt - six;
                g2_next = v + lt + pl + six;
            end
            MODE_FIXED: begin
                e0_next = v;
            end
            default: begin
                e0_next = v;
            end
        endcase
    end

    always_comb begin
        p = BW'(pos_c_reg);
        p4 = p <<< 2;
        kind_next = KIND_ZERO;
        num_w = '0;
        den_next = '0;
        unique case (mode)
            MODE_BOX: begin
                if (p > e0_reg && p < e3_reg) begin
                    kind_next = KIND_UNIT;
                end
            end
            MODE_TRAP: begin
                den_next = DEN_W'(cfg.slope);
                priority if (p < e0_reg) begin
                    kind_next = KIND_ZERO;
                end else if (p < e1_reg) begin
                    kind_next = KIND_RAMP_UP;
                    num_w = p - e0_reg;
                end else if (p < e2_reg) begin
                    kind_next = KIND_UNIT;
                end else if (p < e3_reg) begin
                    kind_next = KIND_RAMP_DOWN;
                    num_w = p - e2_reg;
                end else begin
                    kind_next = KIND_ZERO;
                end
            end
            MODE_GAUSS: begin
                den_next = DEN_W'(cfg.sigma);
                priority if (p < e0_reg) begin
                    kind_next = KIND_ZERO;
                end else if (p < e1_reg) begin
                    if (p > g1_reg) begin
                        kind_next = KIND_GAUSS;
                        num_w = e1_reg - p;
                    end
                end else if (p < e2_reg) begin
                    kind_next = KIND_UNIT;
                end else if (p < e3_reg) begin
                    if (p < g2_reg) begin
                        kind_next = KIND_GAUSS;
                        num_w = p - e2_reg;
                    end
                end else begin
                    kind_next = KIND_ZERO;
                end
            end
            MODE_FIXED: begin
                if (x_axis) begin
                    priority if (p < T2) begin
                        kind_next = KIND_ZERO;
                    end else if (p < T13) begin
                        kind_next = KIND_LEVEL;
                    end else if (p < T20) begin
                        kind_next = KIND_RAMP_UP;
                        num_w = p4 - OFF_UP;
                        den_next = DEN_W'(DEN_UP);
                    end else if (p < T65) begin
                        kind_next = KIND_UNIT;
                    end else if (p < T82) begin
                        kind_next = KIND_RAMP_UP;
                        num_w = OFF_DN - p4;
                        den_next = DEN_W'(DEN_DN);
                    end else if (p < T112) begin
                        kind_next = KIND_LEVEL;
                    end else begin
                        kind_next = KIND_ZERO;
                    end
                end else begin
                    kind_next = KIND_UNIT;
                end
            end
            default: begin
                kind_next = KIND_ZERO;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            tag_reg.valid <= 1'b0;
        end else if (adv) begin
            valid_b_reg <= in_valid;
            valid_c_reg <= valid_b_reg;
            tag_reg.valid <= valid_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pos_b_reg <= pos;
            lt_reg <= lt_next;
            pos_c_reg <= pos_b_reg;
            e0_reg <= e0_next;
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            e3_reg <= e3_next;
            g1_reg <= g1_next;
            g2_reg <= g2_next;
            tag_reg.kind <= kind_next;
            num_reg <= REM_W'(num_w);
            den_reg <= den_next;
        end
    end

    assign tag = tag_reg;
    assign num = num_reg;
    assign den = den_reg;

endmodule

// File: rtl/dpe_div.sv
module dpe_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  dpe_pkg::tag_t             in_tag,
    input  logic [dpe_pkg::REM_W-1:0] num,
    input  logic [dpe_pkg::DEN_W-1:0] den,
    output dpe_pkg::tag_t             out_tag,
    output logic [dpe_pkg::Q_W-1:0]   quo
);
    import dpe_pkg::*;

    tag_t             tag_reg [Q_W];
    logic [REM_W-1:0] rem_reg [Q_W-1];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   q_reg [Q_W];

    // Each stage resolves one quotient bit, most significant first; the
    // numerator is below eight times the divisor on entry.
    for (genvar j = 0; j < Q_W; j++) begin : g_step
        tag_t             tag_in;
        logic [REM_W-1:0] rem_in, den4, rem_sub;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        logic             take;

        if (j == 0) begin : g_first
            assign tag_in = in_tag;
            assign rem_in = num;
            assign den_in = den;
            assign q_in = '0;
        end else begin : g_rest
            assign tag_in = tag_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign q_in = q_reg[j-1];
        end

        assign den4 = REM_W'({den_in, 2'b00});
        assign take = rem_in >= den4;
        assign rem_sub = take ? rem_in - den4 : rem_in;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[j].valid <= 1'b0;
            end else if (adv) begin
                tag_reg[j].valid <= tag_in.valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                tag_reg[j].kind <= tag_in.kind;
                den_reg[j] <= den_in;
                q_reg[j] <= {q_in[Q_W-2:0], take};
            end
        end

        if (j < Q_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[j] <= {rem_sub[REM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_tag = tag_reg[Q_W-1];
    assign quo = q_reg[Q_W-1];

endmodule

// File: rtl/dpe_back.sv
module dpe_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  dpe_pkg::tag_t           in_tag,
    input  logic [dpe_pkg::Q_W-1:0] quo,
    output logic                    out_valid,
    output logic [dpe_pkg::F_W-1:0] factor
);
    import dpe_pkg::*;

    tag_t              tag_e_reg, tag_f_reg, tag_g_reg;
    logic              valid_h_reg;
    logic [U_W-1:0]    u_next, u_reg;
    logic [F_W-1:0]    fd_next, fd_e_reg, fd_f_reg, fd_g_reg;
    logic [EXP_ADDR_W-1:0] idx_a, idx_b;
    logic [WORD_W-1:0] frac_next, frac_reg;
    logic [TAB_W-1:0]  a_next, b_next, a_f_reg, diff_reg, a_g_reg;
    logic              sat_f_reg, sat_g_reg;
    logic [TAB_W+WORD_W-1:0] prod;
    logic [TAB_W-1:0]  prod_hi_reg;
    logic [TAB_W-1:0]  val;
    logic [TAB_W-1:0]  rounded;
    logic [F_W-1:0]    f_next, f_reg;

    always_comb begin
        u_next = U_W'((2 * Q_W)'(quo) * (2 * Q_W)'(quo) >> 1);
        unique case (in_tag.kind)
            KIND_UNIT:      fd_next = UNIT;
            KIND_LEVEL:     fd_next = LEVEL_LOW;
            KIND_RAMP_UP:   fd_next = quo[F_W-1:0];
            KIND_RAMP_DOWN: fd_next = UNIT - quo[F_W-1:0];
            default:        fd_next = '0;
        endcase
    end

    always_comb begin
        idx_a = EXP_ADDR_W'(u_reg[U_W-2 -: EXP_IDX_W]);
        idx_b = idx_a + EXP_ADDR_W'(1);
        frac_next = WORD_W'(u_reg[U_W-2-EXP_IDX_W:0]) << (EXP_IDX_W - 4);
        a_next = EXP_TAB[idx_a];
        b_next = EXP_TAB[idx_b];
    end

    always_comb begin
        prod = (TAB_W + WORD_W)'(diff_reg) * (TAB_W + WORD_W)'(frac_reg);
        val = a_g_reg - prod_hi_reg;
        rounded = (val + TAB_W'(8192)) >> 14;
        if (tag_g_reg.kind == KIND_GAUSS) begin
            f_next = sat_g_reg ? '0 : F_W'(rounded);
        end else begin
            f_next = fd_g_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_e_reg.valid <= 1'b0;
            tag_f_reg.valid <= 1'b0;
            tag_g_reg.valid <= 1'b0;
            valid_h_reg <= 1'b0;
        end else if (adv) begin
            tag_e_reg.valid <= in_tag.valid;
            tag_f_reg.valid <= tag_e_reg.valid;
            tag_g_reg.valid <= tag_f_reg.valid;
            valid_h_reg <= tag_g_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_e_reg.kind <= in_tag.kind;
            u_reg <= u_next;
            fd_e_reg <= fd_next;
            tag_f_reg.kind <= tag_e_reg.kind;
            fd_f_reg <= fd_e_reg;
            sat_f_reg <= u_reg[U_W-1];
            a_f_reg <= a_next;
            diff_reg <= a_next - b_next;
            frac_reg <= frac_next;
            tag_g_reg.kind <= tag_f_reg.kind;
            fd_g_reg <= fd_f_reg;
            sat_g_reg <= sat_f_reg;
            a_g_reg <= a_f_reg;
            prod_hi_reg <= TAB_W'(prod >> WORD_W);
            f_reg <= f_next;
        end
    end

    assign out_valid = valid_h_reg;
    assign factor = f_reg;

endmodule

// File: rtl/density_profile_2d_eval.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  pos_x, pos_y
// m_        out        m_tvalid/m_tready  density
// cfg_      in         cfg_valid/cfg_ready register index and 64-bit data
//
// One position is taken per cycle while the output is not stalled; its density is
// shown on m_tdata after the front end, divider, back end and output registers.
// A 19-stage divider sits between the region decode and the exp table lookup.
// Reset clears all valid bits and the configuration registers.
// When m_tready is low with a result pending, the whole pipeline holds.
module density_profile_2d_eval (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // pos_x [31:0], pos_y [63:32]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // density [16:0], zero [23:17]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dpe_pkg::REG_W-1:0]       cfg_data
);
    import dpe_pkg::*;

    mode_t            mode_reg;
    logic [REG_W-1:0] vac_reg, plasma_reg, slope_reg, sigma_reg, cut_reg, plateau_reg;
    axis_cfg_t        cfg_x, cfg_y;

    logic                    adv;
    logic                    in_valid_reg;
    logic signed [POS_W-1:0] px_reg, py_reg;

    tag_t             tag_fx, tag_fy, tag_dx, tag_dy;
    logic [REM_W-1:0] num_x, num_y;
    logic [DEN_W-1:0] den_x, den_y;
    logic [Q_W-1:0]   quo_x, quo_y;
    logic             vx, vy;
    logic [F_W-1:0]   fx, fy;

    logic [2*F_W-1:0] prod;
    logic [F_W-1:0]   density_next, density_reg;
    logic             m_tvalid_reg;

    assign adv = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BOX;
            vac_reg <= '0;
            plasma_reg <= '0;
            slope_reg <= '0;
            sigma_reg <= '0;
            cut_reg <= '0;
            plateau_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:    mode_reg <= mode_t'(cfg_data[1:0]);
                CFG_VACUUM:  vac_reg <= cfg_data;
                CFG_PLASMA:  plasma_reg <= cfg_data;
                CFG_SLOPE:   slope_reg <= cfg_data;
                CFG_SIGMA:   sigma_reg <= cfg_data;
                CFG_CUT:     cut_reg <= cfg_data;
                CFG_PLATEAU: plateau_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg_x = '{vac: vac_reg[REG_W-1:WORD_W], plasma: plasma_reg[REG_W-1:WORD_W],
                     slope: slope_reg[REG_W-1:WORD_W], sigma: sigma_reg[REG_W-1:WORD_W],
                     cut: cut_reg[REG_W-1:WORD_W], plateau: plateau_reg[REG_W-1:WORD_W]};
    assign cfg_y = '{vac: vac_reg[WORD_W-1:0], plasma: plasma_reg[WORD_W-1:0],
                     slope: slope_reg[WORD_W-1:0], sigma: sigma_reg[WORD_W-1:0],
                     cut: cut_reg[WORD_W-1:0], plateau: plateau_reg[WORD_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg <= s_tdata[POS_W-1:0];
            py_reg <= s_tdata[2*POS_W-1:POS_W];
        end
    end

    dpe_front u_front_x (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .x_axis(1'b1),
        .in_valid(in_valid_reg), .pos(px_reg), .mode(mode_reg), .cfg(cfg_x),
        .tag(tag_fx), .num(num_x), .den(den_x)
    );

    dpe_front u_front_y (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .x_axis(1'b0),
        .in_valid(in_valid_reg), .pos(py_reg), .mode(mode_reg), .cfg(cfg_y),
        .tag(tag_fy), .num(num_y), .den(den_y)
    );

    dpe_div u_div_x (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_tag(tag_fx),
        .num(num_x), .den(den_x), .out_tag(tag_dx), .quo(quo_x)
    );

    dpe_div u_div_y (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_tag(tag_fy),
        .num(num_y), .den(den_y), .out_tag(tag_dy), .quo(quo_y)
    );

    dpe_back u_back_x (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_tag(tag_dx),
        .quo(quo_x), .out_valid(vx), .factor(fx)
    );

    dpe_back u_back_y (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_tag(tag_dy),
        .quo(quo_y), .out_valid(vy), .factor(fy)
    );

    always_comb begin
        prod = (2 * F_W)'(fx) * (2 * F_W)'(fy);
        density_next = F_W'((prod + (2 * F_W)'(32768)) >> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vx && vy;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            density_reg <= density_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {7'b0, density_reg};

endmodule

// File: rtl/dpe_check.sv
module dpe_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result changed while stalled.");

    a_density_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[16:0] <= 17'h10000 && m_tdata[23:17] == 7'd0)
        else $error("Density above one or fill bits set.");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("Input stalled with the output free.");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("Request taken while the pipeline is held.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result valid right after reset.");

endmodule

bind density_profile_2d_eval dpe_check u_dpe_check (.*);

// File: tb/density_profile_2d_eval_test.sv
`timescale 1ns / 1ps

module density_profile_2d_eval_test;
    import dpe_pkg::*;

    localparam int UNITS = 65536;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_PHASES = 13;
    localparam int PER_PHASE = 100;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        bit          known;
        logic [16:0] val;
    } position_t;

    typedef struct {
        int          cfg_set;
        logic [31:0] x;
        logic [31:0] y;
        bit          known;
        logic [16:0] val;
    } row_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [63:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [23:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_data;

    position_t pending_positions[$];
    logic [16:0] expected_density[$];
    longint exp_q30[0:EXP_TABLE_DEPTH];
    mode_t cur_mode;
    logic [63:0] cur_regs[1:6];
    int errors;
    int densities_seen;
    bit calm;

    density_profile_2d_eval uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void make_exp_table();
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        term = 64'd1 << 48;
        sum = term;
        for (int k = 1; k <= 20; k++) begin
            term = (term * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'(k));
            sum = (k % 2 == 1) ? sum - term : sum + term;
        end
        e = (sum + 64'd32768) >> 16;
        exp_q30[0] = longint'(1) << 30;
        for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
            exp_q30[i] = (exp_q30[i-1] * longint'(e) + 64'h8000_0000) >>> 32;
        end
    endfunction

    function automatic longint reg_word(logic [63:0] r, bit hi);
        return hi ? longint'(r[63:32]) : longint'(r[31:0]);
    endfunction

    function automatic longint gauss_edge(longint dabs, longint sg);
        longint q;
        longint u;
        longint t;
        longint idx;
        longint frac;
        longint a;
        longint b;
        longint val;
        if (sg <= 0 || dabs >= 6 * sg) return 0;
        q = (dabs <<< 16) / sg;
        u = (q * q) >>> 1;
        if (u >= (longint'(16) <<< 32)) return 0;
        t = (u * EXP_TABLE_DEPTH) >>> 4;
        idx = t >>> 32;
        if (idx >= EXP_TABLE_DEPTH) return 0;
        frac = t & 64'hFFFF_FFFF;
        a = exp_q30[idx];
        b = exp_q30[idx + 1];
        val = a - (((a - b) * frac) >>> 32);
        return (val + 8192) >>> 14;
    endfunction

    function automatic longint axis_factor(longint p, bit hi);
        longint v;
        longint l;
        longint s;
        longint sg;
        longint pl;
        longint lt;
        logic [63:0] spread;
        v = reg_word(cur_regs[CFG_VACUUM], hi);
        l = reg_word(cur_regs[CFG_PLASMA], hi);
        s = reg_word(cur_regs[CFG_SLOPE], hi);
        sg = reg_word(cur_regs[CFG_SIGMA], hi);
        pl = reg_word(cur_regs[CFG_PLATEAU], hi);
        spread = 64'(reg_word(cur_regs[CFG_CUT], hi)) * 64'(sg);
        lt = longint'(spread >> FRAC_BITS);
        case (cur_mode)
            MODE_BOX: begin
                return (p > v && p < v + l) ? UNITS : 0;
            end
            MODE_TRAP: begin
                if (p < v) return 0;
                if (p < v + s) return s > 0 ? ((p - v) <<< 16) / s : 0;
                if (p < v + l - s) return UNITS;
                if (p < v + l) begin
                    if (s <= 0 || p - (v + l - s) < 0) return 0;
                    return UNITS - ((p - (v + l - s)) <<< 16) / s;
                end
                return 0;
            end
            default: begin
                if (p < v) return 0;
                if (p < v + lt) return gauss_edge(v + lt - p, sg);
                if (p < v + lt + pl) return UNITS;
                if (p < v + 2 * lt + pl) return gauss_edge(p - v - lt - pl, sg);
                return 0;
            end
        endcase
    endfunction

    function automatic longint two_pi_mark(longint k);
        return (k * 64'd26986075409) >>> (32 - FRAC_BITS);
    endfunction

    function automatic longint fixed_x_factor(longint p);
        longint w;
        longint d;
        if (p < two_pi_mark(2)) return 0;
        if (p < two_pi_mark(13)) return 13107;
        if (p < two_pi_mark(20)) begin
            w = two_pi_mark(20) - two_pi_mark(13);
            d = p - two_pi_mark(13);
            return ((w + 4 * d) <<< 16) / (5 * w);
        end
        if (p < two_pi_mark(65)) return UNITS;
        if (p < two_pi_mark(82)) begin
            w = two_pi_mark(82) - two_pi_mark(65);
            d = p - two_pi_mark(65);
            return ((5 * w - 4 * d) <<< 16) / (5 * w);
        end
        if (p < two_pi_mark(112)) return 13107;
        return 0;
    endfunction

    function automatic logic [16:0] predict_density(logic [31:0] x, logic [31:0] y);
        longint fx;
        longint fy;
        if (cur_mode == MODE_FIXED) begin
            fx = fixed_x_factor(longint'($signed(x)));
            fy = UNITS;
        end else begin
            fx = axis_factor(longint'($signed(x)), 1'b1);
            fy = axis_factor(longint'($signed(y)), 1'b0);
        end
        return 17'((fx * fy + 32768) >>> 16);
    endfunction

    task automatic wait_idle();
        while (pending_positions.size() != 0 || expected_density.size() != 0 || s_tvalid) begin
            @(negedge aclk);
        end
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_config(mode_t mode, logic [63:0] regs[1:6]);
        wait_idle();
        write_reg(CFG_MODE, 64'(mode));
        cur_mode = mode;
        for (int i = 1; i <= 6; i++) begin
            write_reg(CFG_IDX_W'(i), regs[i]);
            cur_regs[i] = regs[i];
        end
    endtask

    function automatic logic [31:0] rand_length(int max_units, bit maybe_zero);
        if (maybe_zero && $urandom_range(0, 4) == 0) return 32'd0;
        return 32'($urandom_range(0, max_units)) * UNITS + 32'($urandom_range(0, UNITS - 1));
    endfunction

    function automatic logic [31:0] rand_position(bit wide);
        if ($urandom_range(0, 3) == 0) return $urandom;
        if (wide) return 32'($urandom_range(0, 760 * UNITS)) - 32'(20 * UNITS);
        return 32'($urandom_range(0, 180 * UNITS)) - 32'(10 * UNITS);
    endfunction

    task automatic queue_position(logic [31:0] x, logic [31:0] y, bit known, logic [16:0] val);
        position_t item;
        item.x = x;
        item.y = y;
        item.known = known;
        item.val = val;
        pending_positions.push_back(item);
    endtask

    // Sender: offers queued positions, predicts each density not given in the row on acceptance.
    initial begin
        int gap;
        s_tvalid = 1'b0;
        s_tdata = '0;
        forever begin
            @(negedge aclk);
            if (pending_positions.size() == 0) begin
                s_tvalid = 1'b0;
            end else begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    gap = $urandom_range(1, 11);
                    s_tvalid = 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                s_tvalid = 1'b1;
                s_tdata = {pending_positions[0].y, pending_positions[0].x};
                do @(posedge aclk); while (!s_tready);
                expected_density.push_back(pending_positions[0].known ? pending_positions[0].val
                    : predict_density(pending_positions[0].x, pending_positions[0].y));
                void'(pending_positions.pop_front());
            end
        end
    end

    // Receiver: random stalls, one long hold-off, checks each density.
    initial begin
        int stall;
        bit held;
        logic [16:0] want;
        stall = 0;
        held = 1'b0;
        m_tready = 1'b1;
        densities_seen = 0;
        forever begin
            @(negedge aclk);
            if (!held && densities_seen >= 550) begin
                held = 1'b1;
                stall = 400;
            end else if (stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 11);
            end
            if (stall > 0) begin
                stall--;
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                densities_seen++;
                if (expected_density.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected density, expected none, actual %0d",
                             $time, m_tdata[16:0]);
                end else begin
                    want = expected_density.pop_front();
                    if (m_tdata[16:0] !== want) begin
                        errors++;
                        $display("%0t: density mismatch, expected %0d, actual %0d",
                                 $time, want, m_tdata[16:0]);
                    end
                end
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        row_t rows[$];
        logic [63:0] regs[1:6];
        int set_now;
        mode_t mode;
        errors = 0;
        calm = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_mode = MODE_BOX;
        for (int i = 1; i <= 6; i++) cur_regs[i] = '0;
        make_exp_table();
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        rows = '{
            '{0, 32'h8000_0000, 32'h8000_0000, 1'b1, 17'd0},
            '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 17'd0},
            '{0, 32'h0000_0000, 32'h0000_0000, 1'b1, 17'd0},
            '{0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 17'd0},
            '{1, 32'h8000_0000, 32'h0000_0000, 1'b1, 17'd0},
            '{1, 32'd31 << 16, 32'h8000_0000, 1'b1, 17'd13107},
            '{1, 32'd188 << 16, 32'h7FFF_FFFF, 1'b1, 17'd65536},
            '{1, 32'd100 << 16, 32'd0, 1'b0, 17'd0},
            '{1, 32'd450 << 16, 32'd0, 1'b0, 17'd0},
            '{1, 32'h7FFF_FFFF, 32'd0, 1'b1, 17'd0},
            '{2, 32'd9 << 16, 32'd25 << 16, 1'b1, 17'd0},
            '{2, 32'd15 << 16, 32'd15 << 16, 1'b0, 17'd0},
            '{2, 32'd30 << 16, 32'd30 << 16, 1'b1, 17'd65536},
            '{2, 32'd45 << 16, 32'd30 << 16, 1'b0, 17'd0},
            '{2, 32'd50 << 16, 32'd30 << 16, 1'b1, 17'd0},
            '{3, 32'd5 << 16, 32'd40 << 16, 1'b1, 17'd0},
            '{3, 32'd20 << 16, 32'd40 << 16, 1'b0, 17'd0},
            '{3, 32'd30 << 16, 32'd40 << 16, 1'b1, 17'd65536},
            '{3, 32'd55 << 16, 32'd42 << 16, 1'b0, 17'd0},
            '{3, 32'd200 << 16, 32'd40 << 16, 1'b1, 17'd0}
        };
        set_now = 0;
        foreach (rows[i]) begin
            if (rows[i].cfg_set != set_now) begin
                set_now = rows[i].cfg_set;
                for (int r = 1; r <= 6; r++) regs[r] = '0;
                case (set_now)
                    1: mode = MODE_FIXED;
                    2: begin
                        mode = MODE_TRAP;
                        regs[CFG_VACUUM] = {32'd10 << 16, 32'd10 << 16};
                        regs[CFG_PLASMA] = {32'd40 << 16, 32'd40 << 16};
                        regs[CFG_SLOPE] = {32'd10 << 16, 32'd10 << 16};
                    end
                    default: begin
                        mode = MODE_GAUSS;
                        regs[CFG_VACUUM] = {32'd10 << 16, 32'd10 << 16};
                        regs[CFG_SIGMA] = {32'd4 << 16, 32'd4 << 16};
                        regs[CFG_CUT] = {32'd3 << 16, 32'd3 << 16};
                        regs[CFG_PLATEAU] = {32'd20 << 16, 32'd20 << 16};
                    end
                endcase
                load_config(mode, regs);
            end
            queue_position(rows[i].x, rows[i].y, rows[i].known, rows[i].val);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode = mode_t'(ph % 4);
            for (int r = 1; r <= 6; r++) begin
                if (ph == 0) begin
                    regs[r] = '0;
                end else if (ph == 1) begin
                    regs[r] = '1;
                end else if (ph == 6) begin
                    regs[r] = {$urandom, $urandom};
                end else begin
                    case (r)
                        1: regs[r] = {rand_length(30, 1), rand_length(30, 1)};
                        2: regs[r] = {rand_length(80, 1), rand_length(80, 1)};
                        3: regs[r] = {rand_length(40, 1), rand_length(40, 1)};
                        4: regs[r] = {rand_length(8, 1), rand_length(8, 1)};
                        5: regs[r] = {rand_length(4, 1), rand_length(4, 1)};
                        default: regs[r] = {rand_length(40, 1), rand_length(40, 1)};
                    endcase
                end
            end
            load_config(mode, regs);
            calm = (ph >= RANDOM_PHASES - 2);
            for (int n = 0; n < PER_PHASE; n++) begin
                queue_position(rand_position(mode == MODE_FIXED), rand_position(1'b0), 1'b0, '0);
            end
        end

        while (pending_positions.size() != 0 || expected_density.size() != 0) begin
            @(negedge aclk);
        end
        repeat (60) @(negedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
